// File: rtl/frt_pkg.sv
package frt_pkg;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    localparam logic [2:0] STAT_SINGLE   = 3'd0;
    localparam logic [2:0] STAT_STORED   = 3'd1;
    localparam logic [2:0] STAT_COMPLETE = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_SWEEP    = 3'd4;

    localparam logic ACT_FRAGMENT = 1'b0;
    localparam logic ACT_SWEEP    = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic [31:0] source_id;
        logic [15:0] frame_seq;
        logic [7:0]  frag_index;
        logic        is_start;
        logic        is_end;
        logic        is_screen;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_source;
        logic [15:0] out_seq;
        logic [8:0]  frame_frags;
        logic [6:0]  slot_index;
        logic        from_camera;
        logic [7:0]  evicted;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_FRAG,
        KIND_SWEEP
    } kind_t;

    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_UPDATE,
        ST_RESULT
    } state_t;

endpackage

// File: rtl/frt_front.sv
module frt_front
    import frt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  in_item_t req,
    output logic     job_valid,
    input  logic     job_pop,
    output job_t     job
);

    job_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    job_t       classified;

    always_comb
    begin
        classified.item = req;
        if (req.action == ACT_SWEEP)
        begin
            classified.kind = KIND_SWEEP;
        end
        else if (req.is_start && req.is_end)
        begin
            classified.kind = KIND_SINGLE;
        end
        else
        begin
            classified.kind = KIND_FRAG;
        end
    end

    assign req_stall = (count_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign job_valid = (count_reg != 2'd0);
    assign pop       = job_pop && job_valid;
    assign job       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/frt_back.sv
module frt_back
    import frt_pkg::*;
#(
    parameter int SLOTS     = 128,
    parameter int MAX_FRAGS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] age_limit,
    input  logic        job_valid,
    output logic        job_pop,
    input  job_t        job,
    output logic        res_valid,
    input  logic        res_ready,
    output out_item_t   res
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = SW + 1;
    localparam int FI = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;

    state_t               state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [CW-1:0]        scan_reg, scan_next;
    logic [SW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 cmp_live_reg, cmp_live_next;
    logic                 free_found_reg, free_found_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic                 alloc_reg, alloc_next;
    logic [7:0]           ev_reg, ev_next;
    out_item_t            res_reg, res_next;

    logic [47:0]          key_mem [SLOTS];
    logic [31:0]          arr_mem [SLOTS];
    logic [8:0]           cnt_mem [SLOTS];
    logic [8:0]           tot_mem [SLOTS];
    logic [MAX_FRAGS-1:0] bits_mem [SLOTS];
    logic [47:0]          key_rd;
    logic [31:0]          arr_rd;
    logic [8:0]           cnt_rd;
    logic [8:0]           tot_rd;
    logic [MAX_FRAGS-1:0] bits_rd;

    logic [SW-1:0]        scan_addr;
    logic                 upd_we;
    logic                 alloc_we;
    logic [8:0]           cnt_wd;
    logic [8:0]           tot_wd;
    logic [MAX_FRAGS-1:0] bits_wd;

    logic [8:0]           cur_cnt;
    logic [8:0]           cur_tot;
    logic [MAX_FRAGS-1:0] cur_bits;
    logic                 in_range;
    logic                 last_cmp;
    logic                 key_hit;
    logic                 aged;
    logic                 complete;

    assign scan_addr = scan_reg[SW-1:0];
    assign res       = res_reg;
    assign last_cmp  = (cmp_idx_reg == SW'(SLOTS - 1));
    assign key_hit   = (key_rd == {job_reg.item.source_id, job_reg.item.frame_seq});
    assign aged      = ((job_reg.item.now_ms - arr_rd) > {16'h0, age_limit});
    assign in_range  = ({1'b0, job_reg.item.frag_index} < 9'(MAX_FRAGS));

    always_ff @(posedge clk)
    begin
        key_rd  <= key_mem[scan_addr];
        arr_rd  <= arr_mem[scan_addr];
        cnt_rd  <= cnt_mem[slot_reg];
        tot_rd  <= tot_mem[slot_reg];
        bits_rd <= bits_mem[slot_reg];
        if (upd_we)
        begin
            cnt_mem[slot_reg]  <= cnt_wd;
            tot_mem[slot_reg]  <= tot_wd;
            bits_mem[slot_reg] <= bits_wd;
        end
        if (alloc_we)
        begin
            key_mem[slot_reg] <= {job_reg.item.source_id, job_reg.item.frame_seq};
            arr_mem[slot_reg] <= job_reg.item.now_ms;
        end
    end

    always_comb
    begin
        cur_cnt  = alloc_reg ? 9'd0 : cnt_rd;
        cur_tot  = alloc_reg ? 9'd0 : tot_rd;
        cur_bits = alloc_reg ? '0 : bits_rd;
        cnt_wd   = cur_cnt;
        tot_wd   = cur_tot;
        bits_wd  = cur_bits;
        if (in_range)
        begin
            if (!cur_bits[job_reg.item.frag_index[FI-1:0]])
            begin
                bits_wd[job_reg.item.frag_index[FI-1:0]] = 1'b1;
                cnt_wd = cur_cnt + 9'd1;
            end
            if (job_reg.item.is_end)
            begin
                tot_wd = {1'b0, job_reg.item.frag_index} + 9'd1;
            end
        end
        complete = (tot_wd != 9'd0) && (cnt_wd == tot_wd);
    end

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        valid_next      = valid_reg;
        scan_next       = scan_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_live_next   = 1'b0;
        free_found_next = free_found_reg;
        slot_next       = slot_reg;
        alloc_next      = alloc_reg;
        ev_next         = ev_reg;
        res_next        = res_reg;
        job_pop         = 1'b0;
        res_valid       = 1'b0;
        upd_we          = 1'b0;
        alloc_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop         = 1'b1;
                    job_next        = job;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    alloc_next      = 1'b0;
                    ev_next         = 8'd0;
                    res_next        = '0;
                    if (job.kind == KIND_SINGLE)
                    begin
                        res_next.status      = STAT_SINGLE;
                        res_next.out_source  = job.item.source_id;
                        res_next.out_seq     = job.item.frame_seq;
                        res_next.from_camera = !job.item.is_screen;
                        state_next           = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_reg < CW'(SLOTS))
                begin
                    scan_next     = scan_reg + CW'(1);
                    cmp_idx_next  = scan_addr;
                    cmp_live_next = 1'b1;
                end
                if (cmp_live_reg)
                begin
                    if (job_reg.kind == KIND_SWEEP)
                    begin
                        if (valid_reg[cmp_idx_reg] && aged)
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                            if (ev_reg != 8'hFF)
                            begin
                                ev_next = ev_reg + 8'd1;
                            end
                        end
                        if (last_cmp)
                        begin
                            res_next.status  = STAT_SWEEP;
                            res_next.evicted = ev_next;
                            state_next       = ST_RESULT;
                        end
                    end
                    else
                    begin
                        res_next.out_source  = job_reg.item.source_id;
                        res_next.out_seq     = job_reg.item.frame_seq;
                        res_next.from_camera = !job_reg.item.is_screen;
                        if (valid_reg[cmp_idx_reg] && key_hit)
                        begin
                            slot_next  = cmp_idx_reg;
                            state_next = ST_FETCH;
                        end
                        else
                        begin
                            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                slot_next       = cmp_idx_reg;
                            end
                            if (last_cmp)
                            begin
                                if (free_found_next)
                                begin
                                    alloc_next = 1'b1;
                                    state_next = ST_UPDATE;
                                end
                                else
                                begin
                                    res_next.status = STAT_FULL;
                                    state_next      = ST_RESULT;
                                end
                            end
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                upd_we                = 1'b1;
                alloc_we              = alloc_reg;
                valid_next[slot_reg]  = !complete;
                res_next.slot_index   = 7'(slot_reg);
                if (complete)
                begin
                    res_next.status      = STAT_COMPLETE;
                    res_next.frame_frags = tot_wd;
                end
                else
                begin
                    res_next.status = STAT_STORED;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            scan_reg       <= '0;
            cmp_live_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            alloc_reg      <= 1'b0;
            ev_reg         <= 8'd0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            scan_reg       <= scan_next;
            cmp_live_reg   <= cmp_live_next;
            free_found_reg <= free_found_next;
            alloc_reg      <= alloc_next;
            ev_reg         <= ev_next;
        end
    end

endmodule

// File: rtl/fragment_reassembly_tracker_unit.sv
// channel | handshake            | payload
// req     | req_valid/req_stall  | in_item_t  (fragment header or sweep)
// rsp     | rsp_valid/rsp_stall  | out_item_t (one per item)
// cfg     | cfg_valid/cfg_ready  | cfg_data   (eviction age in ms)
// a pass-through item goes straight to the result; a fragment scans until it hits slot i,
// a sweep or a dropped fragment scans every slot, a fragment that takes a new slot scans
// every slot and then writes it; the scan reads the slot memories one slot a cycle
// a two-entry queue takes items while the scan runs; the rsp register holds a result
// reset clears valid bits, queue, state and sets the eviction age to 2000
// cfg_ready is always high
module fragment_reassembly_tracker_unit
    import frt_pkg::*;
#(
    parameter int SLOTS     = 128,
    parameter int MAX_FRAGS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  in_item_t    req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output out_item_t   rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0] timeout_reg;
    logic        rsp_valid_reg, rsp_valid_next;
    out_item_t   rsp_reg;
    logic        job_valid;
    logic        job_pop;
    job_t        job;
    logic        res_valid;
    logic        res_ready;
    out_item_t   res;

    frt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    frt_back #(
        .SLOTS     (SLOTS),
        .MAX_FRAGS (MAX_FRAGS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .age_limit  (timeout_reg),
        .job_valid  (job_valid),
        .job_pop    (job_pop),
        .job        (job),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign cfg_ready = 1'b1;
    assign res_ready = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef SYNTH
    a_evict_only_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.evicted == 8'd0 || rsp.status == STAT_SWEEP))
        else $error("eviction count on a non-sweep result");

    a_complete_has_total: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == STAT_COMPLETE) |-> (rsp.frame_frags != 9'd0))
        else $error("completed frame with zero total");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (timeout_reg == $past(cfg_data)))
        else $error("timeout register missed a write");
`endif

endmodule

// File: test/fragment_reassembly_tracker_unit_tb.sv
`timescale 1ns / 100ps

module fragment_reassembly_tracker_unit_tb;
    import frt_pkg::*;

    localparam int NSLOT = 128;
    localparam int NFRAG = 256;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    in_item_t    req;
    logic        rsp_valid;
    logic        rsp_stall;
    out_item_t   rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    logic [15:0]  tmo;
    logic         sv_valid [NSLOT];
    logic [31:0]  sv_src [NSLOT];
    logic [15:0]  sv_seq [NSLOT];
    logic [31:0]  sv_arr [NSLOT];
    logic [8:0]   sv_tot [NSLOT];
    logic [8:0]   sv_cnt [NSLOT];
    logic [255:0] sv_map [NSLOT];

    out_item_t expected_q [$];
    int  errors;
    int  idle_cycles;
    bit  hold_rsp;
    int  hold_len;
    int  rsp_wait;
    logic [31:0] clock_ms;

    fragment_reassembly_tracker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic out_item_t track_fragment(in_item_t it);
        out_item_t r;
        int hit;
        int fr;
        int ev;
        r = '0;
        hit = -1;
        fr = -1;
        if (it.action == ACT_SWEEP)
        begin
            ev = 0;
            for (int i = 0; i < NSLOT; i++)
            begin
                if (sv_valid[i] && (it.now_ms - sv_arr[i]) > {16'd0, tmo})
                begin
                    sv_valid[i] = 1'b0;
                    if (ev < 255)
                        ev++;
                end
            end
            r.status = STAT_SWEEP;
            r.evicted = ev[7:0];
            return r;
        end
        r.out_source = it.source_id;
        r.out_seq = it.frame_seq;
        r.from_camera = ~it.is_screen;
        if (it.is_start && it.is_end)
        begin
            r.status = STAT_SINGLE;
            return r;
        end
        for (int i = 0; i < NSLOT; i++)
        begin
            if (sv_valid[i])
            begin
                if (sv_src[i] == it.source_id && sv_seq[i] == it.frame_seq)
                begin
                    hit = i;
                    break;
                end
            end
            else if (fr < 0)
                fr = i;
        end
        if (hit < 0)
        begin
            if (fr < 0)
            begin
                r.status = STAT_FULL;
                return r;
            end
            hit = fr;
            sv_valid[hit] = 1'b1;
            sv_src[hit] = it.source_id;
            sv_seq[hit] = it.frame_seq;
            sv_arr[hit] = it.now_ms;
            sv_tot[hit] = '0;
            sv_cnt[hit] = '0;
            sv_map[hit] = '0;
        end
        if (!sv_map[hit][it.frag_index])
        begin
            sv_map[hit][it.frag_index] = 1'b1;
            sv_cnt[hit] = sv_cnt[hit] + 9'd1;
        end
        if (it.is_end)
            sv_tot[hit] = {1'b0, it.frag_index} + 9'd1;
        r.slot_index = hit[6:0];
        if (sv_tot[hit] != 0 && sv_cnt[hit] == sv_tot[hit])
        begin
            sv_valid[hit] = 1'b0;
            r.status = STAT_COMPLETE;
            r.frame_frags = sv_tot[hit];
        end
        else
            r.status = STAT_STORED;
        return r;
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_q.push_back(track_fragment(it));
    endtask

    task automatic send_frag(logic [31:0] now, logic [31:0] src, logic [15:0] seq,
                             logic [7:0] idx, logic st, logic en, logic scr);
        in_item_t it;
        it = '0;
        it.action = ACT_FRAGMENT;
        it.now_ms = now;
        it.source_id = src;
        it.frame_seq = seq;
        it.frag_index = idx;
        it.is_start = st;
        it.is_end = en;
        it.is_screen = scr;
        send_item(it);
    endtask

    task automatic send_sweep(logic [31:0] now);
        in_item_t it;
        it = '0;
        it.action = ACT_SWEEP;
        it.now_ms = now;
        it.source_id = $urandom;
        it.frame_seq = 16'($urandom);
        it.frag_index = 8'($urandom);
        it.is_start = 1'($urandom);
        it.is_end = 1'($urandom);
        it.is_screen = 1'($urandom);
        send_item(it);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (NSLOT + 20) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] val);
        drain();
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tmo = val;
    endtask

    always @(posedge clk)
    begin
        out_item_t e;
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected item status %0d", rsp.status);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (rsp.status !== e.status)
                    begin $error("status exp %0d got %0d", e.status, rsp.status); errors++; end
                if (rsp.out_source !== e.out_source)
                    begin $error("out_source exp %0h got %0h", e.out_source, rsp.out_source);
                    errors++; end
                if (rsp.out_seq !== e.out_seq)
                    begin $error("out_seq exp %0h got %0h", e.out_seq, rsp.out_seq); errors++; end
                if (rsp.frame_frags !== e.frame_frags)
                    begin $error("frame_frags exp %0d got %0d", e.frame_frags, rsp.frame_frags);
                    errors++; end
                if (rsp.slot_index !== e.slot_index)
                    begin $error("slot_index exp %0d got %0d", e.slot_index, rsp.slot_index);
                    errors++; end
                if (rsp.from_camera !== e.from_camera)
                    begin $error("from_camera exp %0d got %0d", e.from_camera, rsp.from_camera);
                    errors++; end
                if (rsp.evicted !== e.evicted)
                    begin $error("evicted exp %0d got %0d", e.evicted, rsp.evicted); errors++; end
            end
        end
    end

    // receiver stalls, with a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_len <= 0;
            rsp_wait <= 0;
        end
        else if (hold_rsp && hold_len < 600)
        begin
            rsp_stall <= 1'b1;
            hold_len <= hold_len + 1;
        end
        else if (rsp_wait > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_wait <= rsp_wait - 1;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            w = $urandom_range(0, 10);
            rsp_stall <= (w != 0);
            rsp_wait <= (w != 0) ? w - 1 : 0;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_singles();
        send_frag(32'd0, 32'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b0);
        send_frag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_directed_frames();
        send_frag(32'd100, 32'h1, 16'd5, 8'd0, 1'b1, 1'b0, 1'b0);
        send_frag(32'd101, 32'h1, 16'd5, 8'd0, 1'b0, 1'b0, 1'b0);
        send_frag(32'd102, 32'h1, 16'd5, 8'd2, 1'b0, 1'b1, 1'b0);
        send_frag(32'd103, 32'h1, 16'd5, 8'd2, 1'b0, 1'b1, 1'b1);
        send_frag(32'd104, 32'h1, 16'd5, 8'd1, 1'b0, 1'b0, 1'b1);
        send_frag(32'd110, 32'h2, 16'd7, 8'd255, 1'b0, 1'b1, 1'b0);
        send_frag(32'd111, 32'h3, 16'd7, 8'd3, 1'b0, 1'b0, 1'b0);
        send_frag(32'd112, 32'h3, 16'd7, 8'd1, 1'b0, 1'b1, 1'b0);
        send_frag(32'd113, 32'h3, 16'd7, 8'd0, 1'b0, 1'b0, 1'b0);
        send_frag(32'd114, 32'h3, 16'd7, 8'd1, 1'b0, 1'b1, 1'b0);
        send_frag(32'd120, 32'h4, 16'd9, 8'd0, 1'b0, 1'b1, 1'b0);
        send_sweep(32'd2114);
        send_sweep(32'd2200);
        send_sweep(32'hFFFF_0000);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NSLOT; i++)
            send_frag(32'd5000, 32'h100 + i, 16'd1, 8'd0, 1'b0, 1'b0, i[0]);
        send_frag(32'd5001, 32'hDEAD, 16'd2, 8'd0, 1'b1, 1'b0, 1'b0);
        send_frag(32'd5001, 32'h105, 16'd1, 8'd0, 1'b0, 1'b1, 1'b0);
        send_frag(32'd5002, 32'hDEAD, 16'd2, 8'd0, 1'b0, 1'b0, 1'b1);
        send_sweep(32'd5000);
        send_sweep(32'd9000);
    endtask

    task automatic test_backpressure();
        hold_rsp = 1'b1;
        for (int i = 0; i < 8; i++)
            send_frag(clock_ms, $urandom, 16'($urandom), 8'($urandom), 1'b1, 1'b1,
                      1'($urandom));
        hold_rsp = 1'b0;
    endtask

    task automatic test_random(int n);
        logic [31:0] srcs [4];
        int sent;
        int nf;
        logic [15:0] seq;
        logic [31:0] src;
        for (int k = 0; k < 4; k++)
            srcs[k] = $urandom;
        sent = 0;
        while (sent < n)
        begin
            clock_ms = clock_ms + $urandom_range(0, 400);
            case ($urandom_range(0, 9))
                0: begin send_sweep(clock_ms); sent++; end
                1: begin
                    send_frag($urandom, $urandom, 16'($urandom), 8'($urandom), 1'($urandom),
                              1'($urandom), 1'($urandom));
                    sent++;
                end
                default: begin
                    src = srcs[$urandom_range(0, 3)];
                    seq = 16'($urandom_range(0, 7));
                    nf = ($urandom_range(0, 20) == 0) ? $urandom_range(1, 256)
                                                      : $urandom_range(1, 6);
                    for (int f = 0; f < nf && sent < n; f++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            continue;
                        send_frag(clock_ms + 32'(f), src, seq,
                                  8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, nf - 1)
                                                                 : f),
                                  f == 0, f == nf - 1, 1'($urandom));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        hold_rsp = 1'b0;
        idle_cycles = 0;
        clock_ms = 32'hFFFF_0000;
        tmo = TIMEOUT_RESET;
        for (int i = 0; i < NSLOT; i++)
            sv_valid[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_singles();
        test_directed_frames();
        test_table_full();
        write_timeout(16'd0);
        send_sweep(32'd0);
        test_backpressure();
        write_timeout(16'hFFFF);
        test_random(300);
        write_timeout(16'd0);
        test_random(80);
        write_timeout(16'd700);
        test_random(300);
        write_timeout(TIMEOUT_RESET);
        test_random(300);
        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
